// ===== hw/rtl/bdq_pkg.sv =====
// Package for the bounded double-ended queue with search.
// Holds sizes, command codes and status codes; depends on nothing.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== hw/rtl/bounded_deque_with_search_core.sv =====
// Bounded double-ended queue with search and remove, held in a circular store.
// Uses bdq_pkg for sizes and codes; the store is a memory with a registered read port.
// Push, pop, clear and no-op requests pass from idle through the finish state to the result.
// Search reads values from the front in order, stopping at the first match or the last value.
// Remove then moves each value behind the match one place forward and cuts the length by one.
// One request in flight, next taken once the result shows; reset clears control, not the store.
`timescale 1ns / 1ps

module bounded_deque_with_search_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [bdq_pkg::VAL_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [bdq_pkg::ST_W-1:0]      o_status,
    output logic [bdq_pkg::LEN_W-1:0]     o_length,
    output logic                          o_is_empty
);
    import bdq_pkg::*;

    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [CW-1:0]     r_rpos, n_rpos;
    logic [CW-1:0]     r_cpos, n_cpos;
    logic              r_dv, n_dv;
    logic              r_res_found, n_res_found;
    logic [ST_W-1:0]   r_res_status, n_res_status;
    logic              r_ov, n_ov;
    logic              r_o_found, n_o_found;
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [CW-1:0]     r_o_len, n_o_len;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  r_q;
    logic [AW-1:0]     raddr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [VAL_W-1:0]  wdata;
    logic              hit;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(f) + SW'(p);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_found     = r_o_found;
    assign o_status    = r_o_status;
    assign o_length    = LEN_W'(r_o_len);
    assign o_is_empty  = (r_o_len == '0);

    assign hit = r_dv && (r_q == r_val);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_rpos       = r_rpos;
        n_cpos       = r_cpos;
        n_dv         = r_dv;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_ov         = r_ov;
        n_o_found    = r_o_found;
        n_o_status   = r_o_status;
        n_o_len      = r_o_len;
        raddr        = slot_of(r_front, r_rpos);
        we           = 1'b0;
        waddr        = slot_of(r_front, r_count);
        wdata        = i_value;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_val        = i_value;
                    n_res_found  = 1'b0;
                    n_res_status = ST_OK;
                    n_rpos       = '0;
                    n_dv         = 1'b0;
                    n_state      = S_FIN;
                    case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
                                we      = 1'b1;
                                waddr   = n_front;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_front = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    if (r_cmd == CMD_SEARCH) begin
                        n_res_found = 1'b1;
                        n_state     = S_FIN;
                    end else begin
                        n_rpos  = r_cpos + CW'(1);
                        n_dv    = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else if (r_dv && (r_cpos == r_count - CW'(1))) begin
                    n_res_status = ST_NOT_FOUND;
                    n_dv         = 1'b0;
                    n_state      = S_FIN;
                end else if (r_rpos < r_count) begin
                    n_dv   = 1'b1;
                    n_cpos = r_rpos;
                    n_rpos = r_rpos + CW'(1);
                end else begin
                    n_dv = 1'b0;
                end
            end
            S_SHIFT: begin
                we    = r_dv;
                waddr = slot_of(r_front, r_cpos - CW'(1));
                wdata = r_q;
                if (r_rpos < r_count) begin
                    n_dv   = 1'b1;
                    n_cpos = r_rpos;
                    n_rpos = r_rpos + CW'(1);
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_count     = r_count - CW'(1);
                        n_res_found = 1'b1;
                        n_state     = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    n_ov       = 1'b1;
                    n_o_found  = r_res_found;
                    n_o_status = r_res_status;
                    n_o_len    = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_ov    <= n_ov;
        end
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_rpos       <= n_rpos;
        r_cpos       <= n_cpos;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_o_found    <= n_o_found;
        r_o_status   <= n_o_status;
        r_o_len      <= n_o_len;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_q <= mem[raddr];
    end

endmodule
